[hdl/hix_pkg.sv]
// Shared types and constants for the Hilbert curve index-to-cell converter.
// No dependencies; every other file of the block refers to it by scoped names.
package hix_pkg;

    localparam int IDX_W         = 31;  // curve position width
    localparam int CFG_W         = 4;   // curve_order register width
    localparam int ORD_W         = 5;   // effective order, holds up to 31
    localparam int CELL_W        = 16;  // output coordinate width
    localparam int MAX_ORDER_DEF = 15;
    localparam logic [CFG_W-1:0] ORDER_RST = CFG_W'(1);

    // Control that travels with every item down the pipeline.
    typedef struct packed {
        logic             ok;     // index lies in 1..4^order
        logic [ORD_W-1:0] order;  // effective order for this item
        logic [IDX_W-1:0] pos;    // zero-based curve position
    } t_ctl;

endpackage

[hdl/hilbert_index_to_xy.sv]
// Hilbert curve index to (x,y) cell converter, top level.
// Stages: one range-check stage, one stage per curve level 2..MAX_ORDER and one
// output stage. Throughput: one item per cycle while the output is not stalled;
// every stage has its own valid bit, so bubbles close up and the input keeps
// flowing while a result waits at the output.
// Reset (synchronous, i_rst_n low): pipeline empties, curve_order returns to 1.
module hilbert_index_to_xy #(
    parameter int MAX_ORDER = hix_pkg::MAX_ORDER_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [hix_pkg::IDX_W-1:0]  i_curve_index,
    // Output channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [hix_pkg::CELL_W-1:0] o_cell_x,
    output logic [hix_pkg::CELL_W-1:0] o_cell_y,
    output logic                       o_index_ok,
    // Configuration
    input  logic                       i_curve_order_we,
    input  logic [hix_pkg::CFG_W-1:0]  i_curve_order
);

    // Zero-based coordinates at level L stay below 2^L.
    localparam int CW = MAX_ORDER;

    logic [hix_pkg::CFG_W-1:0] r_curve_order;

    // Stage s holds the cell after level s has been applied.
    logic          stg_valid [1:MAX_ORDER];
    logic          stg_ready [1:MAX_ORDER];
    hix_pkg::t_ctl stg_ctl   [1:MAX_ORDER];
    logic [CW-1:0] stg_x     [1:MAX_ORDER];
    logic [CW-1:0] stg_y     [1:MAX_ORDER];
    logic          front_ready;
    logic          back_ready;

    // Configuration register: to be written only while the pipeline is empty; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_order <= hix_pkg::ORDER_RST;
        end else if (i_curve_order_we) begin
            r_curve_order <= i_curve_order;
        end
    end

    // Range check and order-one cell.
    hix_front #(
        .MAX_ORDER (MAX_ORDER),
        .CW        (CW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (front_ready),
        .i_curve_index (i_curve_index),
        .i_curve_order (r_curve_order),
        .o_valid       (stg_valid[1]),
        .i_ready       (stg_ready[1]),
        .o_ctl         (stg_ctl[1]),
        .o_x           (stg_x[1]),
        .o_y           (stg_y[1])
    );

    assign o_stall = !front_ready;

    // One stage per level; a level above the item's order passes the cell on.
    for (genvar lv = 2; lv <= MAX_ORDER; lv++) begin : g_level
        hix_level #(
            .LEVEL (lv),
            .CW    (CW)
        ) u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[lv-1]),
            .o_ready (stg_ready[lv-1]),
            .i_ctl   (stg_ctl[lv-1]),
            .i_x     (stg_x[lv-1]),
            .i_y     (stg_y[lv-1]),
            .o_valid (stg_valid[lv]),
            .i_ready (stg_ready[lv]),
            .o_ctl   (stg_ctl[lv]),
            .o_x     (stg_x[lv]),
            .o_y     (stg_y[lv])
        );
    end

    // Output register: one-based cell, zero for an out-of-range index.
    hix_back #(
        .CW (CW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (stg_valid[MAX_ORDER]),
        .o_ready    (back_ready),
        .i_ctl      (stg_ctl[MAX_ORDER]),
        .i_x        (stg_x[MAX_ORDER]),
        .i_y        (stg_y[MAX_ORDER]),
        .o_valid    (o_valid),
        .i_ready    (!i_stall),
        .o_cell_x   (o_cell_x),
        .o_cell_y   (o_cell_y),
        .o_index_ok (o_index_ok)
    );

    assign stg_ready[MAX_ORDER] = back_ready;

    // An invalid index always comes out as cell (0,0).
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_index_ok |-> o_cell_x == '0 && o_cell_y == '0)
        else $error("invalid item with nonzero cell");

    // A valid index lands on a one-based cell while coordinates fit the port.
    a_valid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (MAX_ORDER < hix_pkg::CELL_W) && o_valid && o_index_ok
        |-> o_cell_x != '0 && o_cell_y != '0)
        else $error("valid item with zero coordinate");

    // The input is held off only when the whole pipeline is backed up.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    // Reset drains the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present right after reset");

endmodule

[hdl/hix_front.sv]
// First pipeline stage: range check, zero-based position and order-one cell.
// Depends on hix_pkg.
module hix_front #(
    parameter int MAX_ORDER = hix_pkg::MAX_ORDER_DEF,
    parameter int CW        = MAX_ORDER
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [hix_pkg::IDX_W-1:0] i_curve_index,
    input  logic [hix_pkg::CFG_W-1:0] i_curve_order,
    output logic                      o_valid,
    input  logic                      i_ready,
    output hix_pkg::t_ctl             o_ctl,
    output logic [CW-1:0]             o_x,
    output logic [CW-1:0]             o_y
);

    localparam logic [hix_pkg::ORD_W-1:0] MAX_K = hix_pkg::ORD_W'(MAX_ORDER);

    logic                        r_valid;
    hix_pkg::t_ctl               r_ctl;
    logic [CW-1:0]               r_x;
    logic [CW-1:0]               r_y;
    hix_pkg::t_ctl               n_ctl;
    logic [CW-1:0]               n_x;
    logic [CW-1:0]               n_y;
    logic [hix_pkg::ORD_W-1:0]   cfg_k;
    logic [hix_pkg::ORD_W:0]     shamt;

    // Clamp the stored order into 1..MAX_ORDER.
    always_comb begin
        cfg_k = {1'b0, i_curve_order};
        if (cfg_k == '0) begin
            cfg_k = hix_pkg::ORD_W'(1);
        end else if (cfg_k > MAX_K) begin
            cfg_k = MAX_K;
        end
        shamt       = {cfg_k, 1'b0};
        n_ctl.order = cfg_k;
        n_ctl.pos   = i_curve_index - hix_pkg::IDX_W'(1);
        n_ctl.ok    = (i_curve_index != '0) && ((n_ctl.pos >> shamt) == '0);
        // Order-one cell, zero based: digit 0..3 gives (0,0),(0,1),(1,1),(1,0).
        n_x         = CW'(n_ctl.pos[1]);
        n_y         = CW'(n_ctl.pos[1] ^ n_ctl.pos[0]);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctl <= n_ctl;
            r_x   <= n_x;
            r_y   <= n_y;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

[hdl/hix_level.sv]
// One curve level as a pipeline stage: reads its base-4 digit and folds the
// lower-level cell into the quadrant. Depends on hix_pkg.
module hix_level #(
    parameter int LEVEL = 2,
    parameter int CW    = hix_pkg::MAX_ORDER_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  hix_pkg::t_ctl i_ctl,
    input  logic [CW-1:0] i_x,
    input  logic [CW-1:0] i_y,
    output logic          o_valid,
    input  logic          i_ready,
    output hix_pkg::t_ctl o_ctl,
    output logic [CW-1:0] o_x,
    output logic [CW-1:0] o_y
);

    localparam logic [CW-1:0] HALF = CW'(1) << (LEVEL - 1);
    localparam logic [CW-1:0] LOW  = HALF - CW'(1);           // 2^(L-1) - 1
    localparam logic [CW-1:0] TOP  = {CW{1'b1}} >> (CW - LEVEL); // 2^L - 1
    localparam int            DSH  = 2 * (LEVEL - 1);

    logic          r_valid;
    hix_pkg::t_ctl r_ctl;
    logic [CW-1:0] r_x;
    logic [CW-1:0] r_y;
    logic [CW-1:0] n_x;
    logic [CW-1:0] n_y;
    logic [1:0]    digit;
    logic          active;

    always_comb begin
        digit  = 2'(i_ctl.pos >> DSH);
        active = i_ctl.order >= hix_pkg::ORD_W'(LEVEL);
        n_x    = i_x;
        n_y    = i_y;
        if (active) begin
            case (digit)
                2'd0: begin
                    n_x = i_y;
                    n_y = i_x;
                end
                2'd1: begin
                    n_y = i_y + HALF;
                end
                2'd2: begin
                    n_x = i_x + HALF;
                    n_y = i_y + HALF;
                end
                default: begin
                    n_x = TOP - i_y;
                    n_y = LOW - i_x;
                end
            endcase
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctl <= i_ctl;
            r_x   <= n_x;
            r_y   <= n_y;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

[hdl/hix_back.sv]
// Output register: converts to one-based cells and zeroes invalid items.
// Depends on hix_pkg.
module hix_back #(
    parameter int CW = hix_pkg::MAX_ORDER_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  hix_pkg::t_ctl              i_ctl,
    input  logic [CW-1:0]              i_x,
    input  logic [CW-1:0]              i_y,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [hix_pkg::CELL_W-1:0] o_cell_x,
    output logic [hix_pkg::CELL_W-1:0] o_cell_y,
    output logic                       o_index_ok
);

    logic                       r_valid;
    logic [hix_pkg::CELL_W-1:0] r_x;
    logic [hix_pkg::CELL_W-1:0] r_y;
    logic                       r_ok;
    logic [CW:0]                sum_x;
    logic [CW:0]                sum_y;
    logic [hix_pkg::CELL_W-1:0] n_x;
    logic [hix_pkg::CELL_W-1:0] n_y;

    always_comb begin
        sum_x = {1'b0, i_x} + (CW + 1)'(1);
        sum_y = {1'b0, i_y} + (CW + 1)'(1);
        n_x   = i_ctl.ok ? hix_pkg::CELL_W'(sum_x) : '0;
        n_y   = i_ctl.ok ? hix_pkg::CELL_W'(sum_y) : '0;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_ok <= i_ctl.ok;
        end
    end

    assign o_valid    = r_valid;
    assign o_cell_x   = r_x;
    assign o_cell_y   = r_y;
    assign o_index_ok = r_ok;

endmodule

[dv/tb_hilbert_index_to_xy.sv]
// Self-checking testbench for hilbert_index_to_xy: a directed table, then random curve positions
// over several curve orders, checked against an in-bench model of the curve walk.
// Depends on hix_pkg and the hilbert_index_to_xy RTL only.
`timescale 1ns / 100ps

module tb_hilbert_index_to_xy;

    // One expected cell; field widths follow the output ports.
    typedef struct packed {
        logic [hix_pkg::CELL_W-1:0] x;
        logic [hix_pkg::CELL_W-1:0] y;
        logic                       ok;
    } t_cell;

    // One row of the directed table. When typed is set, the cell is the one typed
    // into the row; otherwise it comes from hilbert_cell.
    typedef struct packed {
        logic [hix_pkg::CFG_W-1:0]  order;
        logic [hix_pkg::IDX_W-1:0]  idx;
        logic                       typed;
        logic [hix_pkg::CELL_W-1:0] x;
        logic [hix_pkg::CELL_W-1:0] y;
        logic                       ok;
    } t_dir_row;

    localparam int DIR_N      = 24;
    localparam int RAND_ITEMS = 400;
    localparam int PHASES     = 8;
    localparam int DRAIN_WAIT = hix_pkg::MAX_ORDER_DEF + 24;  // maximum order plus margin; exceeds the pipeline depth

    logic                       i_clk;
    logic                       i_rst_n          = 1'b0;
    logic                       i_valid          = 1'b0;
    logic                       o_stall;
    logic [hix_pkg::IDX_W-1:0]  i_curve_index    = '0;
    logic                       o_valid;
    logic                       i_stall          = 1'b0;
    logic [hix_pkg::CELL_W-1:0] o_cell_x;
    logic [hix_pkg::CELL_W-1:0] o_cell_y;
    logic                       o_index_ok;
    logic                       i_curve_order_we = 1'b0;
    logic [hix_pkg::CFG_W-1:0]  i_curve_order    = '0;

    t_cell                     expected_cells[$];   // cells still owed by the block, oldest first
    t_cell                     head_cell;
    logic [hix_pkg::CFG_W-1:0] cur_order = hix_pkg::ORDER_RST; // shadow of curve_order
    bit                        no_idle   = 1'b0;      // suppress gaps and stalls for a phase
    int unsigned               stall_left = 0;
    int unsigned               mismatch_count = 0;
    t_dir_row                  dir_rows [DIR_N];

    hilbert_index_to_xy u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_curve_index    (i_curve_index),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_cell_x         (o_cell_x),
        .o_cell_y         (o_cell_y),
        .o_index_ok       (o_index_ok),
        .i_curve_order_we (i_curve_order_we),
        .i_curve_order    (i_curve_order)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs; a correct run needs a small fraction of this.
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // Walk the curve from the base order-one square up to the effective order.
    // Order zero acts as order one; the 4-bit register cannot exceed the maximum.
    function automatic t_cell hilbert_cell(input logic [hix_pkg::CFG_W-1:0] order_reg,
                                           input logic [hix_pkg::IDX_W-1:0] idx);
        int unsigned     k;
        int unsigned     lvl;
        int unsigned     d;
        int unsigned     half;
        int unsigned     x;
        int unsigned     y;
        int unsigned     t;
        longint unsigned p;
        longint unsigned limit;
        t_cell           c;
        k     = (order_reg == '0) ? 1 : int'(order_reg);
        if (k > hix_pkg::MAX_ORDER_DEF) k = hix_pkg::MAX_ORDER_DEF;
        limit = 64'd1 << (2 * k);
        c     = '0;
        if (idx != '0 && 64'(idx) <= limit) begin
            p = 64'(idx) - 1;
            d = int'(p & 3);
            x = (d >= 2) ? 2 : 1;
            y = (d == 1 || d == 2) ? 2 : 1;
            for (lvl = 2; lvl <= k; lvl++) begin
                half = 1 << (lvl - 1);
                d    = int'((p >> (2 * (lvl - 1))) & 3);
                case (d)
                    0: begin
                        t = x; x = y; y = t;      // lower quadrant: transpose
                    end
                    1: begin
                        y = y + half;             // upper-left: shift up
                    end
                    2: begin
                        x = x + half;             // upper-right: shift both
                        y = y + half;
                    end
                    default: begin
                        t = x;                    // lower-right: flipped transpose
                        x = 2 * half + 1 - y;
                        y = half + 1 - t;
                    end
                endcase
            end
            c.x  = x[hix_pkg::CELL_W-1:0];
            c.y  = y[hix_pkg::CELL_W-1:0];
            c.ok = 1'b1;
        end
        return c;
    endfunction

    // Mostly short idle runs, now and then a long one.
    function automatic int unsigned pick_gap();
        return ($urandom_range(99, 0) < 88) ? $urandom_range(3, 1) : $urandom_range(40, 8);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40) $display("mismatch at %0t: %s", $time, what);
    endtask

    // Offer one item, hold it until the block takes it, then queue its cell.
    task automatic send_item(input logic [hix_pkg::IDX_W-1:0] idx, input t_cell want);
        int unsigned gap;
        gap = (!no_idle && $urandom_range(99, 0) < 30) ? pick_gap() : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_curve_index <= idx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_cells.push_back(want);
    endtask

    // Drain the pipeline, then write curve_order. Every item yields a cell, so an
    // empty queue means nothing is left in flight.
    task automatic set_order(input logic [hix_pkg::CFG_W-1:0] ord);
        i_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge i_clk);
        i_curve_order_we <= 1'b1;
        i_curve_order    <= ord;
        @(posedge i_clk);
        i_curve_order_we <= 1'b0;
        cur_order = ord;
    endtask

    // Output side back-pressure: random stall bursts unless the phase runs without idling.
    always @(posedge i_clk) begin
        if (no_idle) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99, 0) < 25) begin
            i_stall    <= 1'b1;
            stall_left <= pick_gap() - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Compare every accepted cell with the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_cells.size() == 0) begin
                report_mismatch($sformatf("unexpected item x=%0d y=%0d ok=%0b",
                                          o_cell_x, o_cell_y, o_index_ok));
            end else begin
                head_cell = expected_cells.pop_front();
                if (o_cell_x !== head_cell.x)
                    report_mismatch($sformatf("cell_x %0d, want %0d", o_cell_x, head_cell.x));
                if (o_cell_y !== head_cell.y)
                    report_mismatch($sformatf("cell_y %0d, want %0d", o_cell_y, head_cell.y));
                if (o_index_ok !== head_cell.ok)
                    report_mismatch($sformatf("index_ok %0b, want %0b", o_index_ok,
                                              head_cell.ok));
            end
        end
    end

    initial begin : stimulus
        logic [hix_pkg::CFG_W-1:0] phase_order[PHASES];
        logic [hix_pkg::CFG_W-1:0] ord;
        logic [hix_pkg::IDX_W-1:0] idx;
        t_cell                     want;
        int unsigned               eff;
        int unsigned               lim;
        int unsigned               pick;
        int unsigned               n;
        int unsigned               ph;

        // Directed rows. The first ones run at the reset order, before any write.
        // Typed cells: order one square, invalid positions, and the last cell of a
        // full curve, which always lands at (side, 1).
        dir_rows = '{
            '{4'd1,  31'd0,          1'b1, 16'd0,     16'd0, 1'b0},
            '{4'd1,  31'd1,          1'b1, 16'd1,     16'd1, 1'b1},
            '{4'd1,  31'd2,          1'b1, 16'd1,     16'd2, 1'b1},
            '{4'd1,  31'd3,          1'b1, 16'd2,     16'd2, 1'b1},
            '{4'd1,  31'd4,          1'b1, 16'd2,     16'd1, 1'b1},
            '{4'd1,  31'd5,          1'b1, 16'd0,     16'd0, 1'b0},
            '{4'd1,  31'h7FFF_FFFF,  1'b1, 16'd0,     16'd0, 1'b0},
            // order zero behaves as order one
            '{4'd0,  31'd4,          1'b1, 16'd2,     16'd1, 1'b1},
            '{4'd0,  31'd5,          1'b1, 16'd0,     16'd0, 1'b0},
            '{4'd2,  31'd5,          1'b0, 16'd0,     16'd0, 1'b0},
            '{4'd2,  31'd10,         1'b0, 16'd0,     16'd0, 1'b0},
            '{4'd2,  31'd15,         1'b0, 16'd0,     16'd0, 1'b0},
            '{4'd2,  31'd16,         1'b1, 16'd4,     16'd1, 1'b1},
            '{4'd2,  31'd17,         1'b1, 16'd0,     16'd0, 1'b0},
            // largest order: first cell, last cell, one past the end
            '{4'd15, 31'd1,          1'b1, 16'd1,     16'd1, 1'b1},
            '{4'd15, 31'h4000_0000,  1'b1, 16'd32768, 16'd1, 1'b1},
            '{4'd15, 31'h4000_0001,  1'b1, 16'd0,     16'd0, 1'b0},
            '{4'd15, 31'h2AAA_AAAA,  1'b0, 16'd0,     16'd0, 1'b0},
            '{4'd15, 31'h1555_5555,  1'b0, 16'd0,     16'd0, 1'b0},
            '{4'd15, 31'h7FFF_FFFF,  1'b1, 16'd0,     16'd0, 1'b0},
            '{4'd15, 31'd0,          1'b1, 16'd0,     16'd0, 1'b0},
            '{4'd3,  31'd64,         1'b0, 16'd0,     16'd0, 1'b0},
            '{4'd3,  31'd65,         1'b1, 16'd0,     16'd0, 1'b0},
            '{4'd8,  31'd65536,      1'b1, 16'd256,   16'd1, 1'b1}
        };
        phase_order = '{4'd3, 4'd15, 4'd1, 4'd0, 4'd7, 4'd9, 4'd15, 4'd5};
        phase_order[5] = hix_pkg::CFG_W'($urandom_range(15, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < DIR_N; n++) begin
            if (dir_rows[n].order != cur_order) set_order(dir_rows[n].order);
            if (dir_rows[n].typed) begin
                want.x  = dir_rows[n].x;
                want.y  = dir_rows[n].y;
                want.ok = dir_rows[n].ok;
            end else begin
                want = hilbert_cell(cur_order, dir_rows[n].idx);
            end
            send_item(dir_rows[n].idx, want);
        end

        // Random phases, one curve order each; two of them send items back to back with no idling.
        for (ph = 0; ph < PHASES; ph++) begin
            ord = phase_order[ph];
            set_order(ord);
            no_idle = (ph == 2 || ph == 6);
            eff = (ord == '0) ? 1 : int'(ord);
            lim = 1 << (2 * eff);
            for (n = 0; n < RAND_ITEMS / PHASES; n++) begin
                pick = $urandom_range(99, 0);
                if (pick < 70)
                    idx = hix_pkg::IDX_W'($urandom_range(lim, 1));
                else if (pick < 78)
                    idx = hix_pkg::IDX_W'((pick < 74) ? lim : lim + 1);
                else if (pick < 82)
                    idx = '0;
                else if (pick < 85)
                    idx = hix_pkg::IDX_W'(1);
                else
                    idx = hix_pkg::IDX_W'($urandom());
                send_item(idx, hilbert_cell(cur_order, idx));
            end
        end

        // Drop valid, drain the owed cells, then keep watching for stray output.
        i_valid <= 1'b0;
        no_idle = 1'b0;
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
